// ===== rtl/cbc_pkg.sv =====
// Shared constants, codes and helpers for the cartridge bank controller.
`timescale 1ns / 1ps

package cbc_pkg;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_ROM   = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROM_SIZE = 2'd0;
    localparam logic [1:0] REG_RAM_SIZE = 2'd1;
    localparam logic [1:0] REG_HAS_RAM  = 2'd2;

    // ram_size_code values
    localparam logic [1:0] RAM_NONE = 2'd0;
    localparam logic [1:0] RAM_2K   = 2'd1;
    localparam logic [1:0] RAM_8K   = 2'd2;
    localparam logic [1:0] RAM_32K  = 2'd3;

    // bus_address[15:13] regions
    localparam logic [2:0] REGION_RAM_EN   = 3'd0;
    localparam logic [2:0] REGION_ROM_BANK = 3'd1;
    localparam logic [2:0] REGION_RAM_BANK = 3'd2;
    localparam logic [2:0] REGION_MODE     = 3'd3;
    localparam logic [2:0] REGION_EXT_RAM  = 3'd5;

    localparam logic [4:0] RAM_EN_KEY = 5'h0A;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    localparam int ROM_FIELD_BITS = 21;

    typedef logic [ROM_FIELD_BITS-1:0] t_rom_addr;

    // ROM bank mask: min(code,5)+1 low bits set
    function automatic logic [5:0] bank_mask(input logic [3:0] code);
        logic [5:0] m;
        unique case (code)
            4'd0:    m = 6'h01;
            4'd1:    m = 6'h03;
            4'd2:    m = 6'h07;
            4'd3:    m = 6'h0F;
            4'd4:    m = 6'h1F;
            default: m = 6'h3F;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/cbc_req_if.sv =====
// Bus access request and result channel interfaces.
`timescale 1ns / 1ps

interface cbc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, req_type, bus_address, write_data, input ready);
    modport sink   (input valid, req_type, bus_address, write_data, output ready);
endinterface

interface cbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  read_data;
    logic [20:0] rom_address;

    modport source (output valid, result_kind, read_data, rom_address, input ready);
    modport sink   (input valid, result_kind, read_data, rom_address, output ready);
endinterface

// ===== rtl/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: decode, bank registers and external RAM.
// A request beat is registered in the decode stage, then in the result stage.
// Throughput: one beat per unstalled cycle; the RAM's single read/write port serves
// the decode stage, and the RAM read register holds its data while the result stalls.
// Reset (synchronous, active low) clears valid flags, config registers and the bank
// state (ROM bank 1); external RAM contents are not cleared.
`timescale 1ns / 1ps

module cartridge_bank_controller
    import cbc_pkg::*;
#(
    parameter int RAM_BYTES     = 32768,
    parameter int ROM_ADDR_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbc_req_if.sink     i_req,
    cbc_rsp_if.source   o_rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int RamAw = $clog2(RAM_BYTES);
    localparam t_rom_addr RomMask = t_rom_addr'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    // configuration
    logic [3:0] r_rom_size;
    logic [1:0] r_ram_size;
    logic       r_has_ram;
    logic [1:0] cfg_idx;

    // bank state
    logic [5:0] r_rom_bank, n_rom_bank;
    logic [1:0] r_ram_bank, n_ram_bank;
    logic       r_mode,     n_mode;
    logic       r_ram_en,   n_ram_en;

    // decode stage
    logic        r_s1_v;
    logic        r_s1_wr;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data;

    // result stage
    logic        r_s2_v;
    logic [1:0]  r_s2_kind;
    logic [7:0]  r_s2_rd;
    logic        r_s2_use_ram;
    t_rom_addr   r_s2_ra;

    logic [7:0]  mem [RAM_BYTES];
    logic [7:0]  r_ram_q;

    logic        adv1;
    logic        ram_on;
    logic [2:0]  region;
    logic [14:0] ram_idx;
    logic [1:0]  upper;
    logic [6:0]  bank;
    logic [1:0]  n_kind;
    logic [7:0]  n_rd;
    logic        n_use_ram;
    t_rom_addr   n_ra;
    logic        ram_wr;

    // ---------------- configuration port ----------------
    assign o_pready = 1'b1;
    assign cfg_idx  = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size <= '0;
            r_ram_size <= '0;
            r_has_ram  <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (cfg_idx)
                REG_ROM_SIZE: r_rom_size <= i_pwdata[3:0];
                REG_RAM_SIZE: r_ram_size <= i_pwdata[1:0];
                REG_HAS_RAM:  r_has_ram  <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROM_SIZE: o_prdata = {28'd0, r_rom_size};
            REG_RAM_SIZE: o_prdata = {30'd0, r_ram_size};
            REG_HAS_RAM:  o_prdata = {31'd0, r_has_ram};
            default:      o_prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign adv1        = r_s1_v && (!r_s2_v || o_rsp.ready);
    assign i_req.ready = !r_s1_v || adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_wr   <= i_req.req_type;
            r_s1_addr <= i_req.bus_address;
            r_s1_data <= i_req.write_data;
        end
    end

    // ---------------- decode ----------------
    assign region = r_s1_addr[15:13];
    assign ram_on = r_ram_en && (r_ram_size != RAM_NONE);

    always_comb begin
        unique case (r_rom_size)
            4'd5:    upper = {1'b0, r_ram_bank[0]};
            4'd6:    upper = r_ram_bank;
            default: upper = 2'b00;
        endcase
    end

    always_comb begin
        unique case (r_ram_size)
            RAM_32K: ram_idx = r_mode ? {r_ram_bank, r_s1_addr[12:0]} : {2'b00, r_s1_addr[12:0]};
            RAM_2K:  ram_idx = {4'd0, r_s1_addr[10:0]};
            default: ram_idx = {2'b00, r_s1_addr[12:0]};
        endcase
    end

    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_mode     = r_mode;
        n_ram_en   = r_ram_en;
        n_kind     = KIND_READ;
        n_rd       = 8'd0;
        n_use_ram  = 1'b0;
        n_ra       = '0;
        bank       = 7'd0;
        ram_wr     = 1'b0;
        if (r_s1_wr) begin
            n_kind = KIND_WRITE;
            unique case (region)
                REGION_RAM_EN:   n_ram_en = r_has_ram && (r_s1_data[4:0] == RAM_EN_KEY);
                REGION_ROM_BANK: n_rom_bank = (r_s1_data[4:0] != 5'd0)
                                            ? (r_s1_data[5:0] & bank_mask(r_rom_size))
                                            : 6'd1;
                REGION_RAM_BANK: n_ram_bank = r_s1_data[1:0];
                REGION_MODE:     n_mode = r_s1_data[0];
                REGION_EXT_RAM:  ram_wr = ram_on;
                default: ;
            endcase
        end else if (!r_s1_addr[15]) begin
            n_kind = KIND_ROM;
            if (!r_s1_addr[14]) begin
                bank = r_mode ? {upper, 5'd0} : 7'd0;
            end else begin
                bank = {upper, 5'd0} | {1'b0, r_rom_bank};
            end
            n_ra = {bank, r_s1_addr[13:0]} & RomMask;
        end else if (region == REGION_EXT_RAM && ram_on) begin
            n_use_ram = 1'b1;
        end else begin
            n_rd = OPEN_BUS;
        end
    end

    // ---------------- bank state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank <= 6'd1;
            r_ram_bank <= 2'd0;
            r_mode     <= 1'b0;
            r_ram_en   <= 1'b0;
        end else if (adv1) begin
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= n_ram_bank;
            r_mode     <= n_mode;
            r_ram_en   <= n_ram_en;
        end
    end

    // ---------------- external RAM ----------------
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            if (ram_wr) begin
                mem[ram_idx[RamAw-1:0]] <= r_s1_data;
            end
            r_ram_q <= mem[ram_idx[RamAw-1:0]];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (!r_s2_v || o_rsp.ready) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s2_kind    <= n_kind;
            r_s2_rd      <= n_rd;
            r_s2_use_ram <= n_use_ram;
            r_s2_ra      <= n_ra;
        end
    end

    assign o_rsp.valid       = r_s2_v;
    assign o_rsp.result_kind = r_s2_kind;
    assign o_rsp.read_data   = r_s2_use_ram ? r_ram_q : r_s2_rd;
    assign o_rsp.rom_address = r_s2_ra;

endmodule

// ===== rtl/cbc_checker.sv =====
// Port-level checks for the cartridge bank controller, bound to the top level.
`timescale 1ns / 1ps

module cbc_checker
    import cbc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_kind,
    input logic [7:0]  i_rd,
    input logic [20:0] i_ra
);

    // no stray result beats right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_kind == KIND_READ || i_kind == KIND_ROM || i_kind == KIND_WRITE))
        else $error("illegal result kind");

    // ROM address only carried by ROM fetch beats
    a_ra_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_kind != KIND_ROM) |-> (i_ra == '0))
        else $error("rom_address nonzero outside ROM fetch");

    a_write_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_kind != KIND_READ) |-> (i_rd == 8'd0))
        else $error("read_data nonzero outside read beat");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_kind) && $stable(i_rd) && $stable(i_ra)))
        else $error("stalled result beat changed");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_kind      (o_rsp.result_kind),
    .i_rd        (o_rsp.read_data),
    .i_ra        (o_rsp.rom_address)
);

// ===== dv/cartridge_bank_controller_tb.sv =====
// Self-checking testbench for the cartridge bank controller: bus accesses, bank setup and RAM.
`timescale 1ns / 1ps

module cartridge_bank_controller_tb;
    import cbc_pkg::*;

    localparam int RAM_BYTES   = 32768;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        t_rom_addr  rom;
    } t_rsp_beat;

    // Tracks the bank state and RAM contents, and holds the results still owed by the block.
    class bank_scoreboard;
        logic [3:0] rom_code;
        logic [1:0] ram_code;
        logic       has_ram;
        logic [5:0] rom_bank;
        logic [1:0] ram_bank;
        logic       mode;
        logic       ram_en;
        logic [7:0] ram_q [RAM_BYTES];
        bit         seen [RAM_BYTES];
        t_rsp_beat  owed_q [$];
        int         errors;

        function new();
            rom_code = '0;
            ram_code = RAM_NONE;
            has_ram  = 1'b0;
            rom_bank = 6'd1;
            ram_bank = '0;
            mode     = 1'b0;
            ram_en   = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_ROM_SIZE: rom_code = val[3:0];
                REG_RAM_SIZE: ram_code = val[1:0];
                REG_HAS_RAM:  has_ram  = val[0];
                default: ;
            endcase
        endfunction

        function logic [5:0] rom_mask();
            if (rom_code < 4'd5)
                return 6'((1 << (rom_code + 1)) - 1);
            return 6'h3F;
        endfunction

        // bank bits above bit 4, borrowed from the RAM bank on ROM size codes 5 and 6
        function logic [6:0] high_bits();
            case (rom_code)
                4'd5:    return {1'b0, ram_bank[0], 5'b0};
                4'd6:    return {ram_bank, 5'b0};
                default: return 7'd0;
            endcase
        endfunction

        function bit ram_live();
            return ram_en && ram_code != RAM_NONE;
        endfunction

        function logic [14:0] ram_slot(logic [12:0] off);
            int idx;
            case (ram_code)
                RAM_32K: idx = mode ? 8192 * int'(ram_bank) + int'(off) : int'(off);
                RAM_2K:  idx = int'(off) % 2048;
                default: idx = int'(off);
            endcase
            return 15'(idx % RAM_BYTES);
        endfunction

        // a read of a RAM byte that holds nothing defined yet
        function bit blind_read(logic t, logic [15:0] a);
            return !t && a[15:13] == REGION_EXT_RAM && ram_live() && !seen[ram_slot(a[12:0])];
        endfunction

        function void note(logic t, logic [15:0] a, logic [7:0] d);
            t_rsp_beat  e;
            logic [6:0] bank;
            logic [14:0] slot;
            e = '0;
            slot = ram_slot(a[12:0]);
            if (t) begin
                e.kind = KIND_WRITE;
                case (a[15:13])
                    REGION_RAM_EN:   ram_en = has_ram && d[4:0] == RAM_EN_KEY;
                    REGION_ROM_BANK: rom_bank = (d[4:0] == 5'd0) ? 6'd1 : (d[5:0] & rom_mask());
                    REGION_RAM_BANK: ram_bank = d[1:0];
                    REGION_MODE:     mode = d[0];
                    REGION_EXT_RAM: begin
                        if (ram_live()) begin
                            ram_q[slot] = d;
                            seen[slot]  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else if (!a[15]) begin
                e.kind = KIND_ROM;
                if (a[14])
                    bank = {1'b0, rom_bank} | high_bits();
                else
                    bank = mode ? high_bits() : 7'd0;
                e.rom = {bank, a[13:0]};
            end else begin
                e.kind = KIND_READ;
                e.data = (a[15:13] == REGION_EXT_RAM && ram_live()) ? ram_q[slot] : OPEN_BUS;
            end
            owed_q.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check(t_rsp_beat got);
            t_rsp_beat want;
            if (owed_q.size() == 0) begin
                report($sformatf("result beat with none owed (kind %0d)", got.kind));
                return;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
            if (got.data !== want.data)
                report($sformatf("read_data 0x%02h, want 0x%02h", got.data, want.data));
            if (got.rom !== want.rom)
                report($sformatf("rom_address 0x%06h, want 0x%06h", got.rom, want.rom));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [3:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    bit          calm = 1'b0;

    bank_scoreboard sb = new();

    cbc_req_if req ();
    cbc_rsp_if rsp ();

    cartridge_bank_controller dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rsp     (rsp),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 24);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check({rsp.result_kind, rsp.read_data, rsp.rom_address});
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send(input logic t, input logic [15:0] a, input logic [7:0] d);
        if (!calm) begin
            while ($urandom_range(0, 99) < 24) begin
                req.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        if (sb.blind_read(t, a))
            t = 1'b1;
        req.valid       = 1'b1;
        req.req_type    = t;
        req.bus_address = a;
        req.write_data  = d;
        do @(posedge i_clk); while (!req.ready);
        sb.note(t, a, d);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid = 1'b0;
        while (sb.owed_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = 4'({idx, 2'b00});
        i_pwdata  = val;
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    task automatic set_cart(input logic [3:0] rom, input logic [1:0] ram, input logic has);
        drain();
        repeat (4) @(negedge i_clk);
        write_reg(REG_ROM_SIZE, 32'(rom));
        write_reg(REG_RAM_SIZE, 32'(ram));
        write_reg(REG_HAS_RAM, 32'(has));
    endtask

    function automatic logic [12:0] ram_off();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 13'($urandom_range(0, 15));
            5, 6:          return 13'h1FF0 + 13'($urandom_range(0, 15));
            default:       return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic make_access(output logic t, output logic [15:0] a, output logic [7:0] d);
        int r;
        r = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        t = 1'b1;
        if (r < 35) begin
            t = 1'b0;
            if ($urandom_range(0, 6) == 0)
                a = 16'h3FFF + 16'($urandom_range(0, 1)) + 16'h4000 * 16'($urandom_range(0, 1))
                    - 16'h3FFF * 16'($urandom_range(0, 1));
            else
                a = 16'($urandom_range(0, 16'h7FFF));
        end else if (r < 45) begin
            a = 16'h2000 + 16'($urandom_range(0, 16'h1FFF));
            if ($urandom_range(0, 3) == 0)
                d[4:0] = 5'd0;
        end else if (r < 50) begin
            a = 16'h4000 + 16'($urandom_range(0, 16'h1FFF));
        end else if (r < 55) begin
            a = 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
        end else if (r < 63) begin
            a = 16'($urandom_range(0, 16'h1FFF));
            if ($urandom_range(0, 9) < 7)
                d[4:0] = RAM_EN_KEY;
        end else if (r < 78) begin
            a = 16'hA000 + 16'(ram_off());
        end else if (r < 93) begin
            t = 1'b0;
            a = 16'hA000 + 16'(ram_off());
        end else if (r < 97) begin
            t = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
                a = 16'h8000 + 16'($urandom_range(0, 16'h1FFF));
            else
                a = 16'hC000 + 16'($urandom_range(0, 16'h3FFF));
        end else begin
            t = 1'($urandom_range(0, 1));
            a = 16'($urandom_range(0, 16'hFFFF));
        end
    endtask

    task automatic run_phase(input logic [3:0] rom, input logic [1:0] ram, input logic has,
                             input int n, input bit quiet);
        logic        t;
        logic [15:0] a;
        logic [7:0]  d;
        set_cart(rom, ram, has);
        calm = quiet;
        for (int i = 0; i < n; i++) begin
            // halfway through, let everything owed come back before going on
            if (i == n / 2)
                drain();
            make_access(t, a, d);
            send(t, a, d);
        end
        calm = 1'b0;
    endtask

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall = 0;
            else
                stall++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        req.valid       = 1'b0;
        req.req_type    = 1'b0;
        req.bus_address = '0;
        req.write_data  = '0;
        rsp.ready       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // bank state straight out of reset
        send(1'b0, 16'h4000, 8'h00);
        send(1'b0, 16'h0000, 8'h00);

        set_cart(4'd5, RAM_32K, 1'b1);
        send(1'b1, 16'h2000, 8'h00);   // zero bank picks bank 1
        send(1'b0, 16'h7FFF, 8'h00);
        send(1'b1, 16'h3FFF, 8'hFF);
        send(1'b1, 16'h4000, 8'h03);
        send(1'b0, 16'h4000, 8'h00);
        send(1'b0, 16'h0000, 8'h00);
        send(1'b1, 16'h6000, 8'h01);
        send(1'b0, 16'h3FFF, 8'h00);   // mode 1: low window takes upper bits
        send(1'b0, 16'hA000, 8'h00);   // RAM still disabled
        send(1'b1, 16'h0000, 8'hEA);   // key in low 5 bits, junk above
        send(1'b1, 16'hA000, 8'h5A);
        send(1'b1, 16'hBFFF, 8'hA5);
        send(1'b0, 16'hA000, 8'h00);
        send(1'b0, 16'hBFFF, 8'h00);
        send(1'b1, 16'h7FFF, 8'hFE);
        send(1'b1, 16'hA000, 8'h00);
        send(1'b0, 16'hA000, 8'h00);
        send(1'b0, 16'h8000, 8'h00);
        send(1'b0, 16'h9FFF, 8'h00);
        send(1'b0, 16'hC000, 8'h00);
        send(1'b0, 16'hFFFF, 8'h00);
        send(1'b1, 16'hFFFF, 8'h12);
        send(1'b1, 16'h1FFF, 8'h0B);
        send(1'b0, 16'hBFFF, 8'h00);

        set_cart(4'd0, RAM_2K, 1'b0);
        send(1'b1, 16'h2000, 8'h02);   // mask clears the bank to zero
        send(1'b0, 16'h4000, 8'h00);
        send(1'b1, 16'h0000, 8'h0A);   // no RAM on this cart type
        send(1'b0, 16'hA000, 8'h00);

        run_phase(4'd8, RAM_32K, 1'b1, 120, 1'b0);
        run_phase(4'd0, RAM_NONE, 1'b0, 120, 1'b0);
        run_phase(4'd6, RAM_32K, 1'b1, 120, 1'b0);
        run_phase(4'd5, RAM_8K, 1'b1, 120, 1'b1);
        run_phase(4'd1, RAM_2K, 1'b1, 120, 1'b0);
        run_phase(4'd6, RAM_2K, 1'b0, 120, 1'b0);
        run_phase(4'd15, RAM_32K, 1'b1, 120, 1'b0);
        for (int p = 0; p < 3; p++)
            run_phase(4'($urandom_range(0, 8)), 2'($urandom_range(0, 3)),
                      $urandom_range(0, 3) != 0, 120, 1'b0);

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
